// ===== rtl/core/pag_branch_predictor_macros.svh =====
// assertion macros shared by the predictor rtl
`ifndef PAG_BRANCH_PREDICTOR_MACROS_SVH
`define PAG_BRANCH_PREDICTOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define PBP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pbp check failed");

// next-cycle implication, checked outside reset
`define PBP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pbp check failed");

`endif

// ===== rtl/core/pbp_pkg.sv =====
package pbp_pkg;

    typedef enum logic [1:0] {
        CMD_LOOKUP  = 2'd0,
        CMD_UPDATE  = 2'd1,
        CMD_SQUASH  = 2'd2,
        CMD_RESOLVE = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_BHT   = 5'b00100,
        ST_PHT   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    localparam int SNAP_BITS = 10;
    localparam int SAVED_BITS = 10;
    localparam int PC_BITS = 48;

endpackage

// ===== rtl/core/pbp_ram.sv =====
module pbp_ram #(
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 10
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] mem [0:DEPTH-1];
    logic [DATA_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/pag_branch_predictor.sv =====
// per-address two-level branch predictor, one word in flight at a time
// each word passes ST_BHT and then ST_OUT; lookup also passes ST_PHT between them (two dependent ram reads)
// a new word is taken only after the output load, so the history ram read, the counter ram read for lookup
// and the output load (which waits on m_ready while m_valid is held) all lie between accepted words
// reset: after aresetn a clearing pass zeroes both tables, one entry per cycle, until every entry
// of the larger table is cleared; s_ready stays low meanwhile
module pag_branch_predictor #(
    parameter int THREADS      = 2,
    parameter int ADDRESS_BITS = 9,
    parameter int HISTORY_BITS = 10,
    parameter int COUNTER_BITS = 2,
    parameter int INST_SHIFT   = 2
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_command,
    input  logic                             s_thread_id,
    input  logic [pbp_pkg::PC_BITS-1:0]      s_branch_address,
    input  logic                             s_taken,
    input  logic                             s_unconditional,
    input  logic                             s_was_squashed,
    input  logic [pbp_pkg::SAVED_BITS-1:0]   s_saved_history,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_predict_taken,
    output logic [pbp_pkg::SNAP_BITS-1:0]    m_history_snapshot
);
    import pbp_pkg::*;
    `include "pag_branch_predictor_macros.svh"

    localparam int BHT_AW = $clog2(THREADS << ADDRESS_BITS);
    localparam int PHT_AW = HISTORY_BITS;
    localparam int CLR_AW = (BHT_AW > PHT_AW) ? BHT_AW : PHT_AW;
    localparam int BHT_DEPTH = THREADS << ADDRESS_BITS;
    localparam int PHT_DEPTH = 1 << HISTORY_BITS;
    localparam int CLR_LAST = ((BHT_DEPTH > PHT_DEPTH) ? BHT_DEPTH : PHT_DEPTH) - 1;

    state_t state_reg, state_next;
    logic [CLR_AW-1:0] clr_cnt_reg, clr_cnt_next;

    cmd_t                    cmd_reg;
    logic                    tk_reg, unc_reg, sq_reg;
    logic [HISTORY_BITS-1:0] saved_reg;
    logic [BHT_AW-1:0]       slot_reg;
    logic [HISTORY_BITS-1:0] before_reg;
    logic                    pred_reg, pred_next;

    logic                    m_valid_reg, m_valid_next;
    logic                    m_pred_reg;
    logic [SNAP_BITS-1:0]    m_snap_reg;

    logic                    accept, out_load;
    logic                    tid_mod;
    logic [BHT_AW-1:0]       slot_in;

    logic                    bht_we, bht_re;
    logic [BHT_AW-1:0]       bht_waddr;
    logic [HISTORY_BITS-1:0] bht_wdata, bht_rdata;
    logic                    pht_we, pht_re;
    logic [PHT_AW-1:0]       pht_waddr, pht_raddr;
    logic [COUNTER_BITS-1:0] pht_wdata, pht_rdata;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // thread number reduced modulo THREADS; a single thread ignores it
    assign tid_mod = (THREADS > 1) ? s_thread_id : 1'b0;
    assign slot_in = BHT_AW'({tid_mod, s_branch_address[INST_SHIFT +: ADDRESS_BITS]});

    pbp_ram #(.ADDR_BITS(BHT_AW), .DATA_BITS(HISTORY_BITS)) u_bht (
        .aclk  (aclk),
        .we    (bht_we),
        .waddr (bht_waddr),
        .wdata (bht_wdata),
        .re    (bht_re),
        .raddr (slot_in),
        .rdata (bht_rdata)
    );

    pbp_ram #(.ADDR_BITS(PHT_AW), .DATA_BITS(COUNTER_BITS)) u_pht (
        .aclk  (aclk),
        .we    (pht_we),
        .waddr (pht_waddr),
        .wdata (pht_wdata),
        .re    (pht_re),
        .raddr (pht_raddr),
        .rdata (pht_rdata)
    );

    always_comb begin
        bht_re    = accept;
        bht_we    = 1'b0;
        bht_waddr = slot_reg;
        bht_wdata = '0;
        pht_re    = 1'b0;
        pht_raddr = HISTORY_BITS'(s_saved_history);
        pht_we    = 1'b0;
        pht_waddr = saved_reg;
        pht_wdata = '0;
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        pred_next    = pred_reg;

        case (state_reg)
            ST_CLEAR: begin
                bht_we    = 1'b1;
                bht_waddr = clr_cnt_reg[BHT_AW-1:0];
                pht_we    = 1'b1;
                pht_waddr = clr_cnt_reg[PHT_AW-1:0];
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_AW'(CLR_LAST)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // counter read for resolve is started with the history read
                pht_re = accept;
                if (accept) begin
                    state_next = ST_BHT;
                end
            end
            ST_BHT: begin
                pred_next  = 1'b0;
                state_next = ST_OUT;
                case (cmd_reg)
                    CMD_LOOKUP: begin
                        pht_re     = 1'b1;
                        pht_raddr  = bht_rdata;
                        state_next = ST_PHT;
                    end
                    CMD_UPDATE: begin
                        bht_we    = 1'b1;
                        bht_wdata = HISTORY_BITS'({bht_rdata, tk_reg});
                        pred_next = unc_reg;
                    end
                    CMD_SQUASH: begin
                        bht_we    = 1'b1;
                        bht_wdata = saved_reg;
                    end
                    CMD_RESOLVE: begin
                        if (sq_reg) begin
                            bht_we    = 1'b1;
                            bht_wdata = HISTORY_BITS'({saved_reg, tk_reg});
                        end else begin
                            pht_we = 1'b1;
                            if (tk_reg) begin
                                pht_wdata = (&pht_rdata) ? pht_rdata : pht_rdata + 1'b1;
                            end else begin
                                pht_wdata = (|pht_rdata) ? pht_rdata - 1'b1 : pht_rdata;
                            end
                        end
                    end
                    default: begin
                        pred_next = 1'b0;
                    end
                endcase
            end
            ST_PHT: begin
                pred_next  = pht_rdata[COUNTER_BITS-1];
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = out_load || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg   <= cmd_t'(s_command);
            tk_reg    <= s_taken;
            unc_reg   <= s_unconditional;
            sq_reg    <= s_was_squashed;
            saved_reg <= HISTORY_BITS'(s_saved_history);
            slot_reg  <= slot_in;
        end
        if (state_reg == ST_BHT) begin
            before_reg <= bht_rdata;
        end
        pred_reg <= pred_next;
        if (out_load) begin
            m_pred_reg <= pred_reg;
            m_snap_reg <= SNAP_BITS'(before_reg);
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_predict_taken    = m_pred_reg;
    assign m_history_snapshot = m_snap_reg;

    // only one word is in flight
    `PBP_ASSERT_NEXT(a_single_word, aclk, aresetn, accept, !s_ready)
    // ram ports never see a read and a write in the same cycle
    `PBP_ASSERT_NOW(a_bht_port, aclk, aresetn, bht_we, !bht_re)
    `PBP_ASSERT_NOW(a_pht_port, aclk, aresetn, pht_we, !pht_re)
    // squash and resolve never report a taken prediction
    `PBP_ASSERT_NOW(a_pred_zero, aclk, aresetn,
        out_load && (cmd_reg == CMD_SQUASH || cmd_reg == CMD_RESOLVE), !pred_reg)

endmodule
